### hdl/spdc_pkg.sv
// ----------------------------------------------------------------------------
// spdc_pkg
// Shared types and codes for the serial phrase display controller.
// ----------------------------------------------------------------------------
package spdc_pkg;

	// byte classes produced by the front end
	typedef enum logic [3:0] {
		K_TICK,
		K_DASH,
		K_LET_C,
		K_LET_H,
		K_LET_W,
		K_LET_T,
		K_LET_B,
		K_CR,
		K_SPACE,
		K_DIGIT,
		K_VALID,
		K_OTHER
	} kind_t;

	// one classified transaction in the queue
	typedef struct packed {
		kind_t      kind;
		logic [7:0] code;  // space folded to 64, letters uppercased
	} item_t;

	typedef enum logic {
		S_IDLE,
		S_DIV
	} bstate_t;

	localparam logic [3:0] EV_NONE       = 4'd0;
	localparam logic [3:0] EV_GLYPH      = 4'd1;
	localparam logic [3:0] EV_HELP       = 4'd2;
	localparam logic [3:0] EV_CLEARED    = 4'd3;
	localparam logic [3:0] EV_DONE       = 4'd4;
	localparam logic [3:0] EV_INVALID    = 4'd5;
	localparam logic [3:0] EV_FULL       = 4'd6;
	localparam logic [3:0] EV_TIME_OK    = 4'd7;
	localparam logic [3:0] EV_TIME_BAD   = 4'd8;
	localparam logic [3:0] EV_BRIGHT_OK  = 4'd9;
	localparam logic [3:0] EV_BRIGHT_BAD = 4'd10;

	localparam logic [7:0] CODE_CR     = 8'h0D;
	localparam logic [7:0] CODE_DASH   = 8'h2D;
	localparam logic [7:0] CODE_SPACE  = 8'd64;
	localparam logic [7:0] CODE_UNDER  = 8'h5F;

	localparam logic [15:0] FRAME_RESET  = 16'd15625;
	localparam logic [7:0]  BRIGHT_RESET = 8'd34;
	localparam logic [11:0] BRIGHT_NUM   = 12'd3400;
	localparam int          DIV_STEPS    = 12;

endpackage

### hdl/spdc_in_if.sv
// ----------------------------------------------------------------------------
// spdc_in_if
// Input channel: serial byte or frame tick.
// ----------------------------------------------------------------------------
interface spdc_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

### hdl/spdc_out_if.sv
// ----------------------------------------------------------------------------
// spdc_out_if
// Result channel of the controller.
// ----------------------------------------------------------------------------
interface spdc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_res;
	logic [5:0]  glyph_index;
	logic [5:0]  phrase_length;
	logic [7:0]  echo_byte;
	logic [13:0] parsed_value;
	logic [15:0] frame_compare;
	logic [7:0]  bright_compare;

	modport source (output valid, output event_res, output glyph_index,
		output phrase_length, output echo_byte, output parsed_value,
		output frame_compare, output bright_compare, input ready);
	modport sink (input valid, input event_res, input glyph_index,
		input phrase_length, input echo_byte, input parsed_value,
		input frame_compare, input bright_compare, output ready);
endinterface

### hdl/spdc_front.sv
// ----------------------------------------------------------------------------
// spdc_front
// Accept input transactions and classify each byte for the back end.
// ----------------------------------------------------------------------------
module spdc_front (
	spdc_in_if.sink       in,
	input  logic          q_full,
	output logic          push,
	output spdc_pkg::item_t push_item
);
	import spdc_pkg::*;

	logic [7:0] b;
	logic [7:0] up;

	assign in.ready = !q_full;
	assign push     = in.valid && !q_full;

	always_comb begin
		b  = (in.rx_byte == 8'h20) ? CODE_SPACE : in.rx_byte;
		up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
		push_item.code = up;
		if (in.req_type) begin
			push_item.kind = K_TICK;
		end else if (b == CODE_DASH) begin
			push_item.kind = K_DASH;
		end else if (b == 8'h43) begin
			push_item.kind = K_LET_C;
		end else if (b == 8'h48) begin
			push_item.kind = K_LET_H;
		end else if (b == 8'h57) begin
			push_item.kind = K_LET_W;
		end else if (b == 8'h54) begin
			push_item.kind = K_LET_T;
		end else if (b == 8'h42) begin
			push_item.kind = K_LET_B;
		end else if (b == CODE_CR) begin
			push_item.kind = K_CR;
		end else if (b == CODE_SPACE) begin
			push_item.kind = K_SPACE;
		end else if (b >= 8'h30 && b <= 8'h39) begin
			push_item.kind = K_DIGIT;
		end else if (up == 8'h21 || up == 8'h2E || up == 8'h3F || up == 8'h3D ||
				up == 8'h3A || (up >= 8'h41 && up <= 8'h5A)) begin
			push_item.kind = K_VALID;
		end else begin
			push_item.kind = K_OTHER;
		end
	end
endmodule

### hdl/spdc_fifo.sv
// ----------------------------------------------------------------------------
// spdc_fifo
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module spdc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  spdc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output spdc_pkg::item_t pop_item
);
	import spdc_pkg::*;

	item_t      slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_item = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue underflow");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
endmodule

### hdl/spdc_back.sv
// ----------------------------------------------------------------------------
// spdc_back
// Execute classified transactions: console state, phrase store, glyph
// lookup and a shared restoring divider for position wrap and brightness.
// ----------------------------------------------------------------------------
module spdc_back #(
	parameter int PHRASE_DEPTH  = 64,
	parameter int TIME_DIGITS   = 4,
	parameter int BRIGHT_DIGITS = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  spdc_pkg::item_t q_item,
	output logic            pop,
	spdc_out_if.source      out
);
	import spdc_pkg::*;

	localparam int PW = (PHRASE_DEPTH > 2) ? $clog2(PHRASE_DEPTH) : 1;
	localparam int FW = $clog2(PHRASE_DEPTH + 1);

	bstate_t state_q, state_n;
	logic armed_q, armed_n, wmode_q, wmode_n, tmode_q, tmode_n, bmode_q, bmode_n;
	logic [FW-1:0] fill_q, fill_n;
	logic [PW-1:0] show_q, show_n;
	logic [5:0]  glyph_q, glyph_n;
	logic [13:0] accum_q, accum_n;
	logic [2:0]  dcnt_q, dcnt_n;
	logic        stop_q, stop_n;
	logic [15:0] fcmp_q, fcmp_n;
	logic [7:0]  bcmp_q, bcmp_n;
	logic        op_tick_q, op_tick_n;
	logic [13:0] parsed_q, parsed_n;

	// divider
	logic [11:0] dvd_q, dvd_n;
	logic [8:0]  dvs_q, dvs_n;
	logic [8:0]  rem_q, rem_n;
	logic [3:0]  cnt_q, cnt_n;
	logic [9:0]  sh;
	logic        ge;
	logic [9:0]  sub;

	// phrase store
	logic [7:0] mem [PHRASE_DEPTH];
	logic [PHRASE_DEPTH-1:0] vld_q;
	logic [7:0] rd_q;
	logic       rd_vld_q;
	logic       rd_zero_q;
	logic [7:0] rd_byte;
	logic       wr_en;
	logic       rd_en;

	// result register
	logic        out_v_q;
	logic        load;
	logic        slot_free;
	logic [3:0]  ev;
	logic [7:0]  echo;
	logic [13:0] parsed;
	logic [3:0]  ev_q;
	logic [5:0]  glyph_o_q;
	logic [5:0]  len_o_q;
	logic [7:0]  echo_q;
	logic [13:0] parsed_o_q;
	logic [15:0] fcmp_o_q;
	logic [7:0]  bcmp_o_q;

	logic [18:0] prod;
	logic [15:0] tq;
	logic [8:0]  len9;
	logic [6:0]  gmap;
	logic [2:0]  lim;
	logic        valid_ch;

	function automatic logic [6:0] glyph_of(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c == CODE_UNDER || c == 8'h20 || c == CODE_SPACE) begin
			return 7'h40;
		end else if (c == 8'h21) begin
			return {1'b1, 6'd28};
		end else if (c == 8'h3F) begin
			return {1'b1, 6'd27};
		end else if (c == CODE_DASH) begin
			return {1'b1, 6'd41};
		end else if (c == 8'h3D) begin
			return {1'b1, 6'd40};
		end else if (c == 8'h3A) begin
			return {1'b1, 6'd39};
		end else if (c == 8'h2E) begin
			return {1'b1, 6'd42};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'd19;
			return {1'b1, t[5:0]};
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'd64;
			return {1'b1, t[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'd96;
			return {1'b1, t[5:0]};
		end
		return 7'h00;
	endfunction

	assign slot_free = !out_v_q || out.ready;
	assign rd_byte   = rd_vld_q ? rd_q : (rd_zero_q ? CODE_UNDER : 8'h00);
	assign sh        = {rem_q, dvd_q[11]};
	assign ge        = (sh >= {1'b0, dvs_q});
	assign sub       = sh - {1'b0, dvs_q};
	assign gmap      = glyph_of(rd_byte);

	always_comb begin
		state_n = state_q;
		armed_n = armed_q; wmode_n = wmode_q; tmode_n = tmode_q; bmode_n = bmode_q;
		fill_n = fill_q; show_n = show_q; glyph_n = glyph_q;
		accum_n = accum_q; dcnt_n = dcnt_q; stop_n = stop_q;
		fcmp_n = fcmp_q; bcmp_n = bcmp_q; op_tick_n = op_tick_q; parsed_n = parsed_q;
		dvd_n = dvd_q; dvs_n = dvs_q; rem_n = rem_q; cnt_n = cnt_q;
		pop = 1'b0; load = 1'b0; wr_en = 1'b0; rd_en = 1'b0;
		ev = EV_NONE; echo = 8'h00; parsed = 14'd0;
		prod = 19'(accum_q) * 19'd125;
		tq = prod[18:3];
		lim = 3'd0;
		valid_ch = (q_item.kind != K_OTHER && q_item.kind != K_CR &&
			q_item.kind != K_TICK);
		case (state_q)
			S_IDLE: begin
				if (!q_empty && slot_free) begin
					pop = 1'b1;
					if (q_item.kind == K_TICK) begin
						// read the character and wrap the position
						rd_en = 1'b1;
						op_tick_n = 1'b1;
						dvd_n = 12'(show_q) + 12'd1;
						dvs_n = 9'(fill_q);
						rem_n = 9'd0;
						cnt_n = 4'd0;
						state_n = S_DIV;
					end else begin
						load = 1'b1;
						if (q_item.kind == K_DASH && !armed_q) begin
							armed_n = 1'b1;
						end else if (q_item.kind == K_LET_C && armed_q) begin
							fill_n = FW'(1);
							ev = EV_CLEARED;
						end else if (q_item.kind == K_LET_H && armed_q) begin
							ev = EV_HELP;
						end else if (q_item.kind == K_LET_W && armed_q) begin
							wmode_n = 1'b1; fill_n = FW'(1); armed_n = 1'b0;
						end else if (q_item.kind == K_LET_T && armed_q) begin
							tmode_n = 1'b1; armed_n = 1'b0;
							accum_n = 14'd0; dcnt_n = 3'd0; stop_n = 1'b0;
						end else if (q_item.kind == K_LET_B && armed_q) begin
							bmode_n = 1'b1; armed_n = 1'b0;
							accum_n = 14'd0; dcnt_n = 3'd0; stop_n = 1'b0;
						end else if (wmode_q) begin
							if (q_item.kind == K_SPACE && fill_q == FW'(1)) begin
								ev = EV_NONE;
							end else if (q_item.kind == K_CR) begin
								wmode_n = 1'b0;
								ev = EV_DONE;
							end else if (valid_ch) begin
								if (fill_q < FW'(PHRASE_DEPTH)) begin
									wr_en = 1'b1;
									fill_n = fill_q + FW'(1);
								end else begin
									ev = EV_FULL;
								end
							end else begin
								ev = EV_INVALID; echo = q_item.code;
								wmode_n = 1'b0; fill_n = FW'(1);
							end
						end else if (tmode_q || bmode_q) begin
							lim = tmode_q ? 3'(TIME_DIGITS) : 3'(BRIGHT_DIGITS);
							if (q_item.kind == K_CR && tmode_q) begin
								parsed = accum_q;
								tmode_n = 1'b0;
								if (accum_q > 14'd10 && accum_q < 14'd4000) begin
									// round half to even on the three dropped bits
									if (prod[2:0] > 3'd4 || (prod[2:0] == 3'd4 && tq[0])) begin
										fcmp_n = tq + 16'd1;
									end else begin
										fcmp_n = tq;
									end
									ev = EV_TIME_OK;
								end else begin
									ev = EV_TIME_BAD;
								end
							end else if (q_item.kind == K_CR) begin
								bmode_n = 1'b0;
								if (accum_q >= 14'd14 && accum_q <= 14'd100) begin
									load = 1'b0;
									parsed_n = accum_q;
									op_tick_n = 1'b0;
									dvd_n = BRIGHT_NUM;
									dvs_n = 9'(accum_q);
									rem_n = 9'd0;
									cnt_n = 4'd0;
									state_n = S_DIV;
								end else begin
									parsed = accum_q;
									ev = EV_BRIGHT_BAD;
								end
							end else if (q_item.kind != K_SPACE) begin
								if (!stop_q && dcnt_q < lim) begin
									if (q_item.kind == K_DIGIT) begin
										accum_n = 14'(accum_q * 14'd10) +
											14'(q_item.code - 8'h30);
										dcnt_n = dcnt_q + 3'd1;
									end else begin
										stop_n = 1'b1;
									end
								end
							end
						end
					end
				end
			end
			S_DIV: begin
				rem_n = ge ? sub[8:0] : sh[8:0];
				dvd_n = {dvd_q[10:0], ge};
				cnt_n = cnt_q + 4'd1;
				if (cnt_q == 4'(DIV_STEPS - 1)) begin
					load = 1'b1;
					state_n = S_IDLE;
					if (op_tick_q) begin
						show_n = rem_n[PW-1:0];
						if (gmap[6]) begin
							glyph_n = gmap[5:0];
						end
						ev = EV_GLYPH;
					end else begin
						bcmp_n = dvd_n[7:0];
						parsed = parsed_q;
						ev = EV_BRIGHT_OK;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
		len9 = 9'(fill_n) - 9'd1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[PW-1:0]] <= q_item.code;
		end
		if (rd_en) begin
			rd_q      <= mem[show_q];
			rd_vld_q  <= vld_q[show_q];
			rd_zero_q <= (show_q == '0);
		end
		dvd_q <= dvd_n; dvs_q <= dvs_n; rem_q <= rem_n; cnt_q <= cnt_n;
		parsed_q <= parsed_n; op_tick_q <= op_tick_n;
		if (load) begin
			ev_q       <= ev;
			glyph_o_q  <= glyph_n;
			len_o_q    <= len9[5:0];
			echo_q     <= echo;
			parsed_o_q <= parsed;
			fcmp_o_q   <= fcmp_n;
			bcmp_o_q   <= bcmp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			armed_q <= 1'b0; wmode_q <= 1'b0; tmode_q <= 1'b0; bmode_q <= 1'b0;
			fill_q  <= FW'(1);
			show_q  <= '0;
			glyph_q <= 6'd0;
			accum_q <= 14'd0; dcnt_q <= 3'd0; stop_q <= 1'b0;
			fcmp_q  <= FRAME_RESET;
			bcmp_q  <= BRIGHT_RESET;
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_n;
			armed_q <= armed_n; wmode_q <= wmode_n; tmode_q <= tmode_n;
			bmode_q <= bmode_n;
			fill_q  <= fill_n;
			show_q  <= show_n;
			glyph_q <= glyph_n;
			accum_q <= accum_n; dcnt_q <= dcnt_n; stop_q <= stop_n;
			fcmp_q  <= fcmp_n;
			bcmp_q  <= bcmp_n;
			if (wr_en) begin
				vld_q[fill_q[PW-1:0]] <= 1'b1;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out.valid          = out_v_q;
	assign out.event_res      = ev_q;
	assign out.glyph_index    = glyph_o_q;
	assign out.phrase_length  = len_o_q;
	assign out.echo_byte      = echo_q;
	assign out.parsed_value   = parsed_o_q;
	assign out.frame_compare  = fcmp_o_q;
	assign out.bright_compare = bcmp_o_q;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q >= FW'(1) && fill_q <= FW'(PHRASE_DEPTH))
		else $error("fill index out of range");
	a_pop_slot: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (slot_free && state_q == S_IDLE))
		else $error("transaction taken without a free result slot");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q < 4'(DIV_STEPS))
		else $error("divider step count overrun");
	a_tick_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && op_tick_q && load) |=> 9'(show_q) < 9'(fill_q))
		else $error("show position not wrapped");
endmodule

### hdl/serial_phrase_display_controller.sv
// ----------------------------------------------------------------------------
// serial_phrase_display_controller
// Serial command console and phrase-to-glyph sequencer for a display.
// ----------------------------------------------------------------------------
// Every accepted transaction yields exactly one result. A front end takes
// transactions whenever the two-entry queue has room and tags each byte with
// its class; the back end works through the queue one transaction at a time.
// A serial byte is handled in the idle state. A frame tick, and a CR that
// closes an in-range brightness value, also run the twelve steps of the
// shared restoring divider, which wraps the show position plus one modulo
// the phrase length plus one or forms 3400/p. A transaction leaves the queue
// only when the result register is empty or its result is taken in that
// same cycle, so a result that waits at the output holds the back end. The
// phrase store resets through per-entry valid bits, so no clearing pass runs.
module serial_phrase_display_controller #(
	parameter int PHRASE_DEPTH  = 64,
	parameter int TIME_DIGITS   = 4,
	parameter int BRIGHT_DIGITS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	spdc_in_if.sink     in,
	spdc_out_if.source  out
);
	import spdc_pkg::*;

	// queue handshake between the halves
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;
	item_t push_item;
	item_t pop_item;

	// classify each incoming transaction
	spdc_front u_front (
		.in        (in),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decouple acceptance from execution
	spdc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.pop_item  (pop_item)
	);

	// carry out commands, phrase entry and frame ticks
	spdc_back #(
		.PHRASE_DEPTH  (PHRASE_DEPTH),
		.TIME_DIGITS   (TIME_DIGITS),
		.BRIGHT_DIGITS (BRIGHT_DIGITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (pop_item),
		.pop     (pop),
		.out     (out)
	);
endmodule

### tb/spdc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spdc_checker
// Watches both channels, predicts each result of the controller from the
// accepted transactions and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module spdc_checker
	import spdc_pkg::*;
#(
	parameter int PHRASE_DEPTH  = 64,
	parameter int TIME_DIGITS   = 4,
	parameter int BRIGHT_DIGITS = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	spdc_in_if        in,
	spdc_out_if       out,
	output int        fail_count,
	output int        pending
);

	typedef struct packed {
		logic [3:0]  ev;
		logic [5:0]  glyph;
		logic [5:0]  len;
		logic [7:0]  echo;
		logic [13:0] parsed;
		logic [15:0] frame_cmp;
		logic [7:0]  bright_cmp;
	} console_result_t;

	console_result_t result_queue[$];

	logic        armed, wr_mode, tm_mode, br_mode;
	logic [7:0]  phrase_mem [PHRASE_DEPTH];
	int unsigned fill, pos, accum, ndigits;
	logic        stopped;
	logic [5:0]  glyph;
	logic [15:0] frame_cmp;
	logic [7:0]  bright_cmp;

	function automatic logic [7:0] upper(logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'h20 : c;
	endfunction

	function automatic bit printable(logic [7:0] c);
		logic [7:0] u;
		u = upper(c);
		return u == CODE_SPACE || u == "!" || u == "." || u == "?" || u == CODE_DASH ||
			u == "=" || u == ":" || (u >= "0" && u <= "9") || (u >= "A" && u <= "Z");
	endfunction

	task automatic add_digit(logic [7:0] b, int unsigned lim);
		if (stopped || ndigits >= lim)
			return;
		if (b >= "0" && b <= "9") begin
			accum = accum * 10 + (b - "0");
			ndigits++;
		end else
			stopped = 1'b1;
	endtask

	task automatic console_step(logic tick, logic [7:0] raw);
		console_result_t r;
		logic [7:0]  b, c;
		int unsigned prod, q;
		r = '0;
		b = raw;
		if (tick) begin
			c = phrase_mem[pos % PHRASE_DEPTH];
			pos = (pos + 1) % fill;
			if (c == CODE_UNDER || c == 8'h20 || c == CODE_SPACE) glyph = 6'd0;
			else if (c == "!") glyph = 6'd28;
			else if (c == "?") glyph = 6'd27;
			else if (c == CODE_DASH) glyph = 6'd41;
			else if (c == "=") glyph = 6'd40;
			else if (c == ":") glyph = 6'd39;
			else if (c == ".") glyph = 6'd42;
			else if (c >= "0" && c <= "9") glyph = 6'(c - 8'd19);
			else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
				glyph = 6'(upper(c) - 8'd64);
			r.ev = EV_GLYPH;
		end else begin
			if (b == 8'h20) b = CODE_SPACE;
			if (b == CODE_DASH && !armed) armed = 1'b1;
			else if (b == "C" && armed) begin
				fill = 1;
				r.ev = EV_CLEARED;
			end else if (b == "H" && armed) r.ev = EV_HELP;
			else if (b == "W" && armed) begin
				wr_mode = 1'b1; fill = 1; armed = 1'b0;
			end else if ((b == "T" || b == "B") && armed) begin
				if (b == "T") tm_mode = 1'b1; else br_mode = 1'b1;
				accum = 0; ndigits = 0; stopped = 1'b0; armed = 1'b0;
			end else if (wr_mode) begin
				if (b == CODE_SPACE && fill == 1) ;
				else if (b == CODE_CR) begin
					wr_mode = 1'b0;
					r.ev = EV_DONE;
				end else if (printable(b)) begin
					if (fill < PHRASE_DEPTH) begin
						phrase_mem[fill] = upper(b);
						fill++;
					end else
						r.ev = EV_FULL;
				end else begin
					r.ev = EV_INVALID; r.echo = b; wr_mode = 1'b0; fill = 1;
				end
			end else if (tm_mode) begin
				if (b == CODE_CR) begin
					r.parsed = 14'(accum);
					if (accum > 10 && accum < 4000) begin
						prod = 125 * accum;
						q = prod >> 3;
						// round half to even
						if ((prod & 7) > 4 || ((prod & 7) == 4 && q[0])) q++;
						frame_cmp = 16'(q);
						r.ev = EV_TIME_OK;
					end else
						r.ev = EV_TIME_BAD;
					tm_mode = 1'b0;
				end else if (b != CODE_SPACE)
					add_digit(b, TIME_DIGITS);
			end else if (br_mode) begin
				if (b == CODE_CR) begin
					r.parsed = 14'(accum);
					if (accum >= 14 && accum <= 100) begin
						bright_cmp = 8'(3400 / accum);
						r.ev = EV_BRIGHT_OK;
					end else
						r.ev = EV_BRIGHT_BAD;
					br_mode = 1'b0;
				end else if (b != CODE_SPACE)
					add_digit(b, BRIGHT_DIGITS);
			end
		end
		r.glyph      = glyph;
		r.len        = 6'(fill - 1);
		r.frame_cmp  = frame_cmp;
		r.bright_cmp = bright_cmp;
		result_queue.push_back(r);
	endtask

	console_result_t got, want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed = 1'b0; wr_mode = 1'b0; tm_mode = 1'b0; br_mode = 1'b0;
			foreach (phrase_mem[i]) phrase_mem[i] = 8'h00;
			phrase_mem[0] = CODE_UNDER;
			fill = 1; pos = 0; glyph = 6'd0;
			accum = 0; ndigits = 0; stopped = 1'b0;
			frame_cmp = FRAME_RESET; bright_cmp = BRIGHT_RESET;
			fail_count = 0;
			result_queue.delete();
		end else begin
			// compare first: a result can never stem from this edge's input
			if (out.valid && out.ready) begin
				got = {out.event_res, out.glyph_index, out.phrase_length, out.echo_byte,
					out.parsed_value, out.frame_compare, out.bright_compare};
				if (result_queue.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t unexpected result %h", $realtime, got);
				end else begin
					want = result_queue.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display({"%0t mismatch: expected ev %0d gl %0d len %0d",
								" echo %0d val %0d fc %0d bc %0d"},
								$realtime, want.ev, want.glyph, want.len, want.echo,
								want.parsed, want.frame_cmp, want.bright_cmp);
							$display({"    got ev %0d gl %0d len %0d echo %0d",
								" val %0d fc %0d bc %0d"},
								got.ev, got.glyph, got.len, got.echo, got.parsed,
								got.frame_cmp, got.bright_cmp);
						end
					end
				end
			end
			if (in.valid && in.ready)
				console_step(in.req_type, in.rx_byte);
		end
		pending = result_queue.size();
	end

endmodule

### tb/serial_phrase_display_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_phrase_display_controller_tb
// Drives console byte sequences and frame ticks into the controller under
// several idling regimes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module serial_phrase_display_controller_tb;
	import spdc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;

	// idling percentages for sender and receiver
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;
	// long receiver hold-off, counted in its own process
	int unsigned hold_cycles = 0;

	spdc_in_if  in_ch ();
	spdc_out_if out_ch ();

	always #2 clk = ~clk;

	serial_phrase_display_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch.sink),
		.out    (out_ch.source)
	);

	spdc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in         (in_ch),
		.out        (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// receiver: random stalls, plus the long hold-off when one is requested
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else
				out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// offer one transaction, idling at random first; hold it until taken
	task automatic send_item(logic tick, logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.req_type <= tick;
		in_ch.rx_byte  <= b;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(1'b1, 8'($urandom));
	endtask

	// pick a byte a console session would plausibly carry
	function automatic logic [7:0] phrase_byte();
		case ($urandom_range(9))
			0: return 8'h20;
			1: return 8'("0" + $urandom_range(9));
			2: return 8'("a" + $urandom_range(25));
			3: begin
				string p;
				p = "!.?-=:";
				return p[$urandom_range(5)];
			end
			4: return 8'($urandom);
			default: return 8'("A" + $urandom_range(25));
		endcase
	endfunction

	function automatic logic [7:0] number_byte();
		case ($urandom_range(19))
			0: return 8'h20;
			1: return 8'($urandom);
			default: return 8'("0" + $urandom_range(9));
		endcase
	endfunction

	// one random console session or a run of ticks
	task automatic random_session();
		int n;
		case ($urandom_range(9))
			0, 1, 2: begin
				send_text("-W");
				n = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
				repeat (n) send_item(1'b0, phrase_byte());
				if ($urandom_range(4) != 0) send_item(1'b0, CODE_CR);
			end
			3: begin
				send_text($urandom_range(1) ? "-T" : "-B");
				repeat ($urandom_range(6)) send_item(1'b0, number_byte());
				send_item(1'b0, CODE_CR);
			end
			4: send_text($urandom_range(1) ? "-C" : "-H");
			5: repeat ($urandom_range(3)) send_item(1'b0, 8'($urandom));
			default: send_ticks($urandom_range(1, 8));
		endcase
	endtask

	task automatic random_phase(int unsigned n_items, int unsigned s, int unsigned r);
		send_idle = s;
		recv_idle = r;
		repeat (n_items / 6) random_session();
	endtask

	initial begin
		in_ch.valid    = 1'b0;
		in_ch.req_type = 1'b0;
		in_ch.rx_byte  = 8'h00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: ticks on the reset phrase, help, clear, phrase with specials
		send_ticks(2);
		send_text("-H");
		send_text("C");
		send_text("-W");
		send_text(" a!.?-=:09Zz ");
		send_item(1'b0, CODE_CR);
		send_ticks(4);
		// extreme times and brightness, digit limits and a stopped number
		send_text("T10\r-T11\r-T3999\r-T4000\r-B14\r-B100\r-B13\r-B1000\r");
		send_text("-T9x99\r-B\r-W");
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h80);
		send_ticks(1);

		random_phase(400, 0, 0);
		// let the controller fill and stall against a held receiver
		hold_cycles = 200;
		random_phase(60, 0, 0);
		// pause the sender until nothing is outstanding
		in_ch.valid <= 1'b0;
		wait (pending == 0);
		// fill the phrase store to overflow, then show a stale position
		send_text("-W");
		repeat (66) send_item(1'b0, 8'("A" + $urandom_range(25)));
		send_item(1'b0, CODE_CR);
		send_ticks(70);
		send_text("-C");
		send_ticks(3);
		random_phase(250, 47, 0);
		random_phase(250, 0, 47);
		random_phase(250, 14, 14);

		in_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("serial_phrase_display_controller_tb: PASS");
		else
			$display("serial_phrase_display_controller_tb: FAIL");
		$finish;
	end

	initial begin
		#4000000;
		$display("serial_phrase_display_controller_tb: FAIL");
		$finish;
	end

endmodule
